### hdl/dps_pkg.sv
package dps_pkg;

  localparam int unsigned VTX_W  = 5;
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned DIST_W = 21;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef struct packed {
    logic              reached;
    logic [VTX_W-1:0]  vertex;
    logic              last;
    logic [CNT_W-1:0]  count;
    logic [DIST_W-1:0] distance;
  } dps_result_t;

endpackage

### hdl/dfs_path_search.sv
// A load word does not take the block out of idle; it stays ready for the next word.
// A query pops vertices off the stack and scans each candidate neighbor with one
// weight memory read each, then walks the parent chain to collect the path and
// returns the path vertices one output word at a time.
// Reset clears the sequencer, the stack pointer and the output valid flag and sets
// the vertex count to 32; the weight memory holds nothing until it is loaded.
module dfs_path_search #(
  parameter int unsigned MAX_VERTICES = 32,
  parameter int unsigned WEIGHT_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [4:0]  row_i,
  input  logic [4:0]  col_i,
  input  logic [15:0] weight_i,
  input  logic [4:0]  source_i,
  input  logic [4:0]  target_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        reached_o,
  output logic [4:0]  path_vertex_o,
  output logic        last_o,
  output logic [5:0]  visited_count_o,
  output logic [20:0] distance_o
);

  import dps_pkg::*;

  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam int unsigned NW = VW + 1;
  localparam int unsigned CW = (NW > 6) ? NW : 6;
  localparam int unsigned AW = 2 * VW;
  localparam int unsigned SW = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INIT  = 4'd1;
  localparam logic [3:0] S_POP   = 4'd2;
  localparam logic [3:0] S_PCHK  = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_SLAST = 4'd5;
  localparam logic [3:0] S_WALK  = 4'd6;
  localparam logic [3:0] S_WWAIT = 4'd7;
  localparam logic [3:0] S_ERD   = 4'd8;
  localparam logic [3:0] S_EOUT  = 4'd9;
  localparam logic [3:0] S_MISS  = 4'd10;

  logic [3:0]              state_q, state_d;
  logic [5:0]              vc_q;
  logic [NW-1:0]           n_act;
  logic [VW-1:0]           src_q, src_d, dst_q, dst_d, p_q, p_d, cur_q, cur_d;
  logic [VW-1:0]           i_q, i_d, e_q, e_d, eidx_q, eidx_d;
  logic                    ev_q, ev_d;
  logic [NW-1:0]           sp_q, sp_d, len_q, len_d, found_q, found_d;
  logic [MAX_VERTICES-1:0] vis_q, vis_d;
  logic [DIST_W-1:0]       dist_q, dist_d;

  logic                    w_we;
  logic [AW-1:0]           w_waddr, w_raddr;
  logic [WEIGHT_BITS-1:0]  w_rd;
  logic                    s_we, par_we, pw_we;
  logic [VW-1:0]           s_waddr, s_wdata, s_raddr, s_rd;
  logic [VW-1:0]           par_waddr, par_wdata, par_raddr, par_rd;
  logic [VW-1:0]           pw_waddr, pw_raddr;
  logic [DIST_W-1:0]       pw_wdata, pw_rd;
  logic [SW-1:0]           sum;
  logic [DIST_W-1:0]       sat;
  logic                    push;

  logic        out_load, out_free;
  dps_result_t out_d, out_q;

  always_comb begin
    if (vc_q == 6'd0) begin
      n_act = NW'(1);
    end else if (CW'(vc_q) > CW'(MAX_VERTICES)) begin
      n_act = NW'(MAX_VERTICES);
    end else begin
      n_act = NW'(vc_q);
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign w_we    = in_valid_i && in_ready_o && !mode_i &&
                   (CW'(row_i) < CW'(MAX_VERTICES)) && (CW'(col_i) < CW'(MAX_VERTICES));
  assign w_waddr = {VW'(row_i), VW'(col_i)};
  assign w_raddr = {p_q, i_q};

  assign sum  = SW'(pw_rd) + SW'(w_rd);
  assign sat  = (sum > SW'(DIST_MAX)) ? DIST_MAX : DIST_W'(sum);
  assign push = ev_q && (w_rd != '0) && !vis_q[eidx_q] && (sp_q < NW'(MAX_VERTICES));

  always_comb begin
    state_d = state_q;
    src_d = src_q; dst_d = dst_q; p_d = p_q; cur_d = cur_q;
    i_d = i_q; e_d = e_q; eidx_d = eidx_q; ev_d = 1'b0;
    sp_d = sp_q; len_d = len_q; found_d = found_q;
    vis_d = vis_q; dist_d = dist_q;
    s_we = 1'b0; s_waddr = sp_q[VW-1:0]; s_wdata = eidx_q;
    s_raddr = sp_q[VW-1:0] - VW'(1);
    par_we = 1'b0; par_waddr = eidx_q; par_wdata = p_q; par_raddr = cur_q;
    pw_we = 1'b0; pw_waddr = eidx_q; pw_wdata = sat;
    pw_raddr = (state_q == S_PCHK) ? s_rd : p_q;
    out_load = 1'b0;
    out_d = '{reached: 1'b0, vertex: '0, last: 1'b1,
              count: CNT_W'(found_q + NW'(1)), distance: '0};

    if (push) begin
      vis_d[eidx_q] = 1'b1;
      par_we = 1'b1; pw_we = 1'b1; s_we = 1'b1;
      sp_d = sp_q + NW'(1);
      found_d = found_q + NW'(1);
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i && mode_i) begin
          src_d = VW'(source_i);
          dst_d = VW'(target_i);
          found_d = '0;
          sp_d = '0;
          vis_d = '0;
          if ((CW'(source_i) >= CW'(n_act)) || (CW'(target_i) >= CW'(n_act))) begin
            state_d = S_MISS;
          end else begin
            state_d = S_INIT;
          end
        end
      end
      S_INIT: begin
        vis_d[src_q] = 1'b1;
        par_we = 1'b1; par_waddr = src_q; par_wdata = src_q;
        pw_we = 1'b1; pw_waddr = src_q; pw_wdata = '0;
        s_we = 1'b1; s_waddr = '0; s_wdata = src_q;
        sp_d = NW'(1);
        state_d = S_POP;
      end
      S_POP: begin
        if (sp_q == '0) begin
          state_d = S_MISS;
        end else begin
          sp_d = sp_q - NW'(1);
          state_d = S_PCHK;
        end
      end
      S_PCHK: begin
        p_d = s_rd;
        if (s_rd == dst_q) begin
          cur_d = s_rd;
          len_d = '0;
          state_d = S_WALK;
        end else begin
          i_d = VW'(n_act - NW'(1));
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        ev_d = 1'b1;
        eidx_d = i_q;
        if (i_q == '0) begin
          state_d = S_SLAST;
        end else begin
          i_d = i_q - VW'(1);
        end
      end
      S_SLAST: begin
        state_d = S_POP;
      end
      S_WALK: begin
        dist_d = pw_rd;
        s_we = 1'b1; s_waddr = len_q[VW-1:0]; s_wdata = cur_q;
        len_d = len_q + NW'(1);
        if (cur_q == src_q) begin
          e_d = len_q[VW-1:0];
          state_d = S_ERD;
        end else begin
          state_d = S_WWAIT;
        end
      end
      S_WWAIT: begin
        cur_d = par_rd;
        state_d = S_WALK;
      end
      S_ERD: begin
        s_raddr = e_q;
        state_d = S_EOUT;
      end
      S_EOUT: begin
        s_raddr = e_q;
        out_d = '{reached: 1'b1, vertex: VTX_W'(s_rd), last: (e_q == '0),
                  count: CNT_W'(found_q + NW'(1)), distance: dist_q};
        if (out_free) begin
          out_load = 1'b1;
          if (e_q == '0) begin
            state_d = S_IDLE;
          end else begin
            e_d = e_q - VW'(1);
            state_d = S_ERD;
          end
        end
      end
      S_MISS: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vc_q    <= 6'd32;
      sp_q    <= '0;
      ev_q    <= 1'b0;
      vis_q   <= '0;
      found_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        vc_q <= cfg_wdata_i;
      end
      sp_q    <= sp_d;
      ev_q    <= ev_d;
      vis_q   <= vis_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q  <= src_d;
    dst_q  <= dst_d;
    p_q    <= p_d;
    cur_q  <= cur_d;
    i_q    <= i_d;
    e_q    <= e_d;
    eidx_q <= eidx_d;
    len_q  <= len_d;
    dist_q <= dist_d;
  end

  dps_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(1 << AW)) u_weight (
    .clk_i(clk_i), .we_i(w_we), .waddr_i(w_waddr), .wdata_i(WEIGHT_BITS'(weight_i)),
    .raddr_i(w_raddr), .rdata_o(w_rd)
  );

  dps_ram #(.WIDTH(VW), .DEPTH(1 << VW)) u_stack (
    .clk_i(clk_i), .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(s_raddr), .rdata_o(s_rd)
  );

  dps_ram #(.WIDTH(VW), .DEPTH(1 << VW)) u_parent (
    .clk_i(clk_i), .we_i(par_we), .waddr_i(par_waddr), .wdata_i(par_wdata),
    .raddr_i(par_raddr), .rdata_o(par_rd)
  );

  dps_ram #(.WIDTH(DIST_W), .DEPTH(1 << VW)) u_pathw (
    .clk_i(clk_i), .we_i(pw_we), .waddr_i(pw_waddr), .wdata_i(pw_wdata),
    .raddr_i(pw_raddr), .rdata_o(pw_rd)
  );

  dps_out_reg u_out (
    .clk_i(clk_i), .rst_ni(rst_ni), .load_i(out_load), .data_i(out_d),
    .free_o(out_free), .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .data_o(out_q)
  );

  assign reached_o       = out_q.reached;
  assign path_vertex_o   = out_q.vertex;
  assign last_o          = out_q.last;
  assign visited_count_o = out_q.count;
  assign distance_o      = out_q.distance;

  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= NW'(MAX_VERTICES))
    else $error("stack pointer beyond depth");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && mode_i) |=> !in_ready_o)
    else $error("query did not hold off input");

  a_miss_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !reached_o) |-> (last_o && distance_o == '0))
    else $error("unreachable word malformed");

  a_push_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> vis_q[$past(eidx_q)])
    else $error("pushed vertex not marked");

endmodule

### hdl/dps_ram.sv
module dps_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### hdl/dps_out_reg.sv
module dps_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  dps_pkg::dps_result_t data_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dps_pkg::dps_result_t data_o
);

  import dps_pkg::*;

  logic        valid_q, valid_d;
  dps_result_t data_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (load_i && free_o) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign data_o      = data_q;

endmodule
